// ----- design/rcps_pkg.sv -----
// ----------------------------------------------------------------------------
// rcps_pkg
// Shared types and codes for the softened coulomb potential sum core.
// ----------------------------------------------------------------------------
package rcps_pkg;

  localparam logic [1:0] CFG_SOFTENING  = 2'd0;
  localparam logic [1:0] CFG_SRC_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SUM_MODE   = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic MODE_DIRECT  = 1'b0;
  localparam logic MODE_CLUSTER = 1'b1;

  localparam logic signed [63:0] POT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] POT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               command;
    logic [9:0]         slot;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] charge;
    logic signed [31:0] weight;
    logic signed [63:0] prior_potential;
  } req_t;

  typedef struct packed {
    logic signed [63:0] potential;
    logic               saturated;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] charge;
    logic signed [31:0] weight;
  } src_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [63:0] term;
  } term_res_t;

endpackage

// ----- design/regularized_coulomb_potential_sum_core.sv -----
// ----------------------------------------------------------------------------
// regularized_coulomb_potential_sum_core
// Softened coulomb potential of stored sources at one target point.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. A load request
// writes one source point into the store and gives no result; a slot at or
// beyond MAX_SOURCES is not written. An evaluate request walks sources
// 0 .. source_count-1 (clamped to MAX_SOURCES); for each one the store is
// read and the term unit runs its multiply steps, a check, the bit-serial
// square root, the one-bit-a-cycle divider and a final step. The term ends
// after the check when the numerator or the distance is zero. After the last
// source (or at once, with a count of zero) a final add with the prior
// potential is made, and done_o is registered from that final-add state.
// The result is on rsp_o in the single cycle that done_o is high and stays
// until the next result; the receiver cannot stall it. Configuration writes
// through cfg_we_i are taken in any cycle and are meant for times when
// busy_o is low. Reset clears control state and configuration; the source
// store is not cleared and an entry must be loaded before it is walked.
// ----------------------------------------------------------------------------
module regularized_coulomb_potential_sum_core #(
  parameter int MAX_SOURCES = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rcps_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output rcps_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [30:0]    cfg_data_i
);
  import rcps_pkg::*;

  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES + 1) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_WT   = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [30:0] eps_q;
  logic [10:0] cnt_q;
  logic        mode_q;
  logic [CW-1:0] j_q, cnt_lim;
  logic signed [31:0] tx_q, ty_q, tz_q;
  logic signed [63:0] prior_q, acc_q;
  logic        sat_q;
  logic        done_q;
  rsp_t        rsp_q;

  logic        accept, mem_we, mem_re, term_start;
  logic [31:0] slot_ext;
  src_t        wsrc, rsrc;
  term_res_t   tres;

  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return {1'b1, a[63] ? POT_MIN : POT_MAX};
    end
    return {1'b0, s};
  endfunction

  assign accept   = start_i && (state_q == ST_IDLE);
  assign slot_ext = {22'b0, req_i.slot};
  assign mem_we   = accept && req_i.command == CMD_LOAD && slot_ext < 32'(MAX_SOURCES);
  assign wsrc     = '{x: req_i.px, y: req_i.py, z: req_i.pz,
                      charge: req_i.charge, weight: req_i.weight};
  assign mem_re   = state_q == ST_RD;
  assign term_start = state_q == ST_WT;

  always_comb begin
    if ({21'b0, cnt_q} > 32'(MAX_SOURCES)) begin
      cnt_lim = CW'(MAX_SOURCES);
    end else begin
      cnt_lim = CW'(cnt_q);
    end
  end

  rcps_src_mem #(
    .DEPTH(MAX_SOURCES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(slot_ext[AW-1:0]),
    .wdata_i(wsrc),
    .re_i   (mem_re),
    .raddr_i(j_q[AW-1:0]),
    .rdata_o(rsrc)
  );

  rcps_term_unit u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(term_start),
    .tx_i   (tx_q),
    .ty_i   (ty_q),
    .tz_i   (tz_q),
    .eps_i  (eps_q),
    .mode_i (mode_q),
    .src_i  (rsrc),
    .res_o  (tres)
  );

  logic [64:0] acc_add, fin_add;
  assign acc_add = sat_add(acc_q, tres.term);
  assign fin_add = sat_add(prior_q, acc_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.command == CMD_EVAL) begin
          state_d = (cnt_lim == '0) ? ST_FIN : ST_RD;
        end
      end
      ST_RD:  state_d = ST_WT;
      ST_WT:  state_d = ST_RUN;
      ST_RUN: begin
        if (tres.done) begin
          state_d = (j_q + CW'(1) == cnt_lim) ? ST_FIN : ST_RD;
        end
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eps_q   <= '0;
      cnt_q   <= '0;
      mode_q  <= MODE_DIRECT;
      j_q     <= '0;
      sat_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == ST_FIN;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOFTENING: eps_q  <= cfg_data_i;
          CFG_SRC_COUNT: cnt_q  <= cfg_data_i[10:0];
          CFG_SUM_MODE:  mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        j_q   <= '0;
        sat_q <= 1'b0;
      end else if (state_q == ST_RUN && tres.done) begin
        j_q   <= j_q + CW'(1);
        sat_q <= sat_q | tres.sat | acc_add[64];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_q    <= req_i.px;
      ty_q    <= req_i.py;
      tz_q    <= req_i.pz;
      prior_q <= req_i.prior_potential;
      acc_q   <= '0;
    end else if (state_q == ST_RUN && tres.done) begin
      acc_q <= acc_add[63:0];
    end
    if (state_q == ST_FIN) begin
      rsp_q.potential <= fin_add[63:0];
      rsp_q.saturated <= sat_q | fin_add[64];
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FIN)) else $error("result without final add");
  a_term_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tres.done |-> state_q == ST_RUN) else $error("term result outside walk");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> j_q < cnt_lim) else $error("walk past source count");
  a_start_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> state_q == ST_WT ##1 state_q == ST_RUN)
    else $error("read to term start sequence broken");

endmodule

// ----- design/rcps_src_mem.sv -----
// ----------------------------------------------------------------------------
// rcps_src_mem
// Source point store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcps_src_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  rcps_pkg::src_t wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output rcps_pkg::src_t rdata_o
);
  import rcps_pkg::*;

  src_t mem [DEPTH];
  src_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rcps_term_unit.sv -----
// ----------------------------------------------------------------------------
// rcps_term_unit
// One source term: shared multiplier, bit-serial isqrt, restoring divider.
// ----------------------------------------------------------------------------
module rcps_term_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] tx_i,
  input  logic signed [31:0] ty_i,
  input  logic signed [31:0] tz_i,
  input  logic [30:0]        eps_i,
  input  logic               mode_i,
  input  rcps_pkg::src_t     src_i,
  output rcps_pkg::term_res_t res_o
);
  import rcps_pkg::*;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_MUL  = 3'd1;
  localparam logic [2:0] T_CHK  = 3'd2;
  localparam logic [2:0] T_SQRT = 3'd3;
  localparam logic [2:0] T_DIV  = 3'd4;
  localparam logic [2:0] T_FIN  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [6:0]  step_q, step_d;
  logic [32:0] ax_q, ay_q, az_q;
  logic [31:0] qm_q, wm_q;
  logic        neg_q;
  logic [65:0] prod_q;
  logic [63:0] r2_q, num_q;
  logic [63:0] v_q, rt_q, bit_q;
  logic [77:0] n_q, quo_q;
  logic [32:0] rem_q;
  term_res_t   res_q, res_d;

  function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? 32'(-33'(a)) : 32'(a);
  endfunction

  // multiplier operand select
  logic [32:0] op_a, op_b;
  always_comb begin
    case (step_q[2:0])
      3'd0:    begin op_a = ax_q; op_b = ax_q; end
      3'd1:    begin op_a = ay_q; op_b = ay_q; end
      3'd2:    begin op_a = az_q; op_b = az_q; end
      3'd3:    begin op_a = {2'b0, eps_i}; op_b = {2'b0, eps_i}; end
      3'd4:    begin op_a = {1'b0, qm_q}; op_b = {1'b0, wm_q}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  logic [63:0] sq_sum;
  logic        sq_ge;
  logic [33:0] rem_sh;
  logic        div_ge;
  logic [63:0] mag;

  always_comb begin
    sq_sum = rt_q + bit_q;
    sq_ge  = v_q >= sq_sum;
    rem_sh = {rem_q, n_q[77]};
    div_ge = rem_sh >= {1'b0, rt_q[32:0]};
    mag    = {1'b0, quo_q[62:0]};
  end

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    res_d  = res_q;
    res_d.done = 1'b0;
    case (st_q)
      T_IDLE: begin
        if (start_i) begin
          st_d   = T_MUL;
          step_d = '0;
        end
      end
      T_MUL: begin
        step_d = step_q + 7'd1;
        if (step_q == 7'd5) begin
          st_d = T_CHK;
        end
      end
      T_CHK: begin
        step_d = '0;
        if (num_q == '0 || (r2_q == '0 && mode_i == MODE_CLUSTER)) begin
          res_d = '{done: 1'b1, sat: 1'b0, term: '0};
          st_d  = T_IDLE;
        end else if (r2_q == '0) begin
          res_d = '{done: 1'b1, sat: 1'b1, term: neg_q ? POT_MIN : POT_MAX};
          st_d  = T_IDLE;
        end else begin
          st_d = T_SQRT;
        end
      end
      T_SQRT: begin
        step_d = step_q + 7'd1;
        if (step_q == 7'd31) begin
          step_d = '0;
          st_d   = T_DIV;
        end
      end
      T_DIV: begin
        step_d = step_q + 7'd1;
        if (step_q == 7'd77) begin
          st_d = T_FIN;
        end
      end
      T_FIN: begin
        if (quo_q[77:63] != '0) begin
          res_d = '{done: 1'b1, sat: 1'b1, term: neg_q ? POT_MIN : POT_MAX};
        end else begin
          res_d = '{done: 1'b1, sat: 1'b0, term: neg_q ? -$signed(mag) : $signed(mag)};
        end
        st_d = T_IDLE;
      end
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= T_IDLE;
      step_q <= '0;
      res_q  <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      res_q  <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= op_a * op_b;
    if (st_q == T_IDLE && start_i) begin
      ax_q  <= absdiff(tx_i, src_i.x);
      ay_q  <= absdiff(ty_i, src_i.y);
      az_q  <= absdiff(tz_i, src_i.z);
      qm_q  <= mag32(src_i.charge);
      wm_q  <= mag32(src_i.weight);
      neg_q <= (mode_i == MODE_CLUSTER) ? src_i.charge[31]
                                        : (src_i.charge[31] ^ src_i.weight[31]);
      r2_q  <= '0;
    end
    if (st_q == T_MUL && step_q != 7'd0) begin
      if (step_q == 7'd5) begin
        num_q <= (mode_i == MODE_CLUSTER) ? {16'b0, qm_q, 16'b0} : prod_q[63:0];
      end else begin
        // squares shifted into Q34.30 before summing
        r2_q <= r2_q + {2'b0, prod_q[63:2]};
      end
    end
    if (st_q == T_CHK) begin
      v_q   <= r2_q;
      rt_q  <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end
    if (st_q == T_SQRT) begin
      if (sq_ge) begin
        v_q  <= v_q - sq_sum;
        rt_q <= (rt_q >> 1) + bit_q;
      end else begin
        rt_q <= rt_q >> 1;
      end
      bit_q <= bit_q >> 2;
      if (step_q == 7'd31) begin
        n_q   <= {num_q, 14'b0} << 1;
        rem_q <= '0;
        quo_q <= '0;
      end
    end
    if (st_q == T_DIV) begin
      rem_q <= div_ge ? 33'(rem_sh - {1'b0, rt_q[32:0]}) : rem_sh[32:0];
      n_q   <= {n_q[76:0], 1'b0};
      quo_q <= {quo_q[76:0], div_ge};
    end
  end

  assign res_o = res_q;

endmodule
